[hdl/smm_pkg.sv]
// -----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants for the square matrix multiplier.
// -----------------------------------------------------------------------------
package smm_pkg;

   localparam int SMM_MAX_SIZE    = 16;   // default largest side length
   localparam int SMM_FIELD_LIMIT = 16;   // largest side the index fields can address
   localparam int SMM_IDX_W       = 4;    // row and column field width
   localparam int SMM_SIZE_W      = 5;    // side length width, holds 1..16
   localparam int SMM_DATA_W      = 32;   // element and sum width

   localparam logic [SMM_SIZE_W-1:0] SMM_SIZE_RESET = 5'd16;

   // request command
   typedef enum logic {
      CMD_WRITE_B  = 1'b0,
      CMD_STREAM_A = 1'b1
   } smm_cmd_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic                  b_write;     // write one B element
      logic                  a_read;      // read the B row for one A element
      logic [SMM_IDX_W-1:0]  row;         // B write row
      logic [SMM_IDX_W-1:0]  col;         // B write column, A column k
      logic [SMM_DATA_W-1:0] value;       // B write data
      logic                  prod_load;   // capture the product
      logic [SMM_DATA_W-1:0] a_value;     // A element in the multiply stage
      logic                  acc_step;    // accumulate stage advances
      logic                  acc_close;   // accumulate stage closes the row
      logic [SMM_SIZE_W-1:0] n;           // side length in the accumulate stage
      logic                  drain_shift; // result chain moves one place
   } smm_cell_ctrl_type;

endpackage

[hdl/smm_if.sv]
// -----------------------------------------------------------------------------
// smm_if
// Request and response channels of the square matrix multiplier.
// -----------------------------------------------------------------------------
interface smm_req_if
   import smm_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   smm_cmd_type                  command;
   logic [SMM_IDX_W-1:0]         row;
   logic [SMM_IDX_W-1:0]         col;
   logic signed [SMM_DATA_W-1:0] value;

   modport source (output valid, command, row, col, value, input ready);
   modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface smm_rsp_if
   import smm_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [SMM_IDX_W-1:0]         out_row;
   logic [SMM_IDX_W-1:0]         out_col;
   logic signed [SMM_DATA_W-1:0] sum;
   logic                         last;

   modport source (output valid, out_row, out_col, sum, last, input ready);
   modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

[hdl/square_matrix_multiply.sv]
// Path: a closing A request passes the multiply stage, the accumulate stage and
// the result chain register before its first sum shows.
// Throughput: one request per cycle unless a close is held; the n sums of a row
// leave one per cycle while rsp is ready; a close waits while the chain drains.
// Reset: synchronous, clears accumulators, valid flags and chain count and sets
// the side length to 16; the B store is undefined until written.
// -----------------------------------------------------------------------------
// square_matrix_multiply
// Integer matrix multiplier C = A * B over a chain of column cells.
// -----------------------------------------------------------------------------
module square_matrix_multiply
   import smm_pkg::*;
#(
   parameter int MAX_SIZE = SMM_MAX_SIZE
) (
   input  logic                  clock,
   input  logic                  reset,
   smm_req_if.sink               req,
   smm_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [SMM_SIZE_W-1:0] csr_wr_data
);

   localparam int CAP = (MAX_SIZE < SMM_FIELD_LIMIT) ? MAX_SIZE : SMM_FIELD_LIMIT;
   localparam logic [SMM_SIZE_W-1:0] CAP_N = SMM_SIZE_W'(CAP);

   logic [SMM_SIZE_W-1:0] size_ff, size_in;
   logic [SMM_SIZE_W-1:0] n_eff;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_close_ff;
   logic [SMM_IDX_W-1:0]  s1_row_ff;
   logic [SMM_SIZE_W-1:0] s1_n_ff;
   logic [SMM_DATA_W-1:0] s1_value_ff;

   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_close_ff;
   logic [SMM_IDX_W-1:0]  s2_row_ff;
   logic [SMM_SIZE_W-1:0] s2_n_ff;

   logic [SMM_SIZE_W-1:0] drain_count_ff, drain_count_in;
   logic [SMM_SIZE_W-1:0] drain_n_ff;
   logic [SMM_IDX_W-1:0]  drain_row_ff;

   logic req_fire, req_ok, b_write, a_read, a_close;
   logic rsp_fire, drain_busy, drain_load;
   logic s2_stall, s1_move, s2_adv;

   smm_cell_ctrl_type     ctrl;
   logic [SMM_DATA_W-1:0] chain [CAP+1];

   // side length register
   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         size_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SMM_SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // saturate the side length to 1..CAP
   always_comb begin
      n_eff = size_ff;
      if (size_ff == '0) begin
         n_eff = SMM_SIZE_W'(1);
      end else if (size_ff > CAP_N) begin
         n_eff = CAP_N;
      end
   end

   // decode the request; drop indices outside the matrix
   assign req_fire = req.valid && req.ready;
   assign req_ok   = req_fire && ({1'b0, req.row} < n_eff) && ({1'b0, req.col} < n_eff);
   assign b_write  = req_ok && (req.command == CMD_WRITE_B);
   assign a_read   = req_ok && (req.command == CMD_STREAM_A);
   assign a_close  = {1'b0, req.col} == (n_eff - SMM_SIZE_W'(1));

   // hold the accumulate stage while a closing row waits for the chain
   assign rsp_fire   = rsp.valid && rsp.ready;
   assign drain_busy = (drain_count_ff != '0) &&
                       !((drain_count_ff == SMM_SIZE_W'(1)) && rsp_fire);
   assign s2_stall   = s2_valid_ff && s2_close_ff && drain_busy;
   assign s2_adv     = s2_valid_ff && !s2_stall;
   assign s1_move    = s1_valid_ff && !s2_stall;
   assign drain_load = s2_adv && s2_close_ff;
   assign req.ready  = !(s1_valid_ff && s2_stall);

   // pipeline valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (a_read) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   // chain occupancy
   always_comb begin
      drain_count_in = drain_count_ff;
      if (drain_load) begin
         drain_count_in = s2_n_ff;
      end else if (rsp_fire) begin
         drain_count_in = drain_count_ff - SMM_SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         drain_count_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         drain_count_ff <= drain_count_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (a_read) begin
         s1_close_ff <= a_close;
         s1_row_ff   <= req.row;
         s1_n_ff     <= n_eff;
         s1_value_ff <= req.value;
      end
      if (s1_move) begin
         s2_close_ff <= s1_close_ff;
         s2_row_ff   <= s1_row_ff;
         s2_n_ff     <= s1_n_ff;
      end
      if (drain_load) begin
         drain_n_ff   <= s2_n_ff;
         drain_row_ff <= s2_row_ff;
      end
   end

   // broadcast to the cells
   always_comb begin
      ctrl.b_write     = b_write;
      ctrl.a_read      = a_read;
      ctrl.row         = req.row;
      ctrl.col         = req.col;
      ctrl.value       = req.value;
      ctrl.prod_load   = s1_move;
      ctrl.a_value     = s1_value_ff;
      ctrl.acc_step    = s2_adv;
      ctrl.acc_close   = s2_close_ff;
      ctrl.n           = s2_n_ff;
      ctrl.drain_shift = rsp_fire;
   end

   // row of column cells, cell 0 faces the output
   assign chain[CAP] = '0;

   for (genvar j = 0; j < CAP; j++) begin : g_cell
      smm_cell #(
         .INDEX (j),
         .DEPTH (CAP)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .chain_in  (chain[j+1]),
         .chain_out (chain[j])
      );
   end

   // response from the head of the chain
   always_comb begin
      logic [SMM_SIZE_W-1:0] col_wide;
      col_wide    = drain_n_ff - drain_count_ff;
      rsp.valid   = drain_count_ff != '0;
      rsp.out_row = drain_row_ff;
      rsp.out_col = col_wide[SMM_IDX_W-1:0];
      rsp.sum     = chain[0];
      rsp.last    = drain_count_ff == SMM_SIZE_W'(1);
   end

   // a stalled close stays in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s2_stall |=> s2_valid_ff && s2_close_ff)
      else $error("closing row left the accumulate stage while the chain was busy");

   // chain occupancy never exceeds the loaded side length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (drain_count_ff <= drain_n_ff) && (drain_n_ff <= CAP_N))
      else $error("result chain count out of range");

   // an accepted A request enters the multiply stage
   a_read_enters: assert property (@(posedge clock) disable iff (reset)
      a_read |=> s1_valid_ff)
      else $error("A request lost before the multiply stage");

   // the multiply stage moves on unless held
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> s2_valid_ff)
      else $error("product lost before the accumulate stage");

endmodule

[hdl/smm_ram.sv]
// -----------------------------------------------------------------------------
// smm_ram
// Generic single write port RAM with one registered read port.
// -----------------------------------------------------------------------------
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/smm_cell.sv]
// -----------------------------------------------------------------------------
// smm_cell
// One column of the result: holds column INDEX of B, multiplies it by the
// streamed A element, accumulates, and passes finished sums down the chain.
// -----------------------------------------------------------------------------
module smm_cell
   import smm_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smm_cell_ctrl_type     ctrl,
   input  logic [SMM_DATA_W-1:0] chain_in,
   output logic [SMM_DATA_W-1:0] chain_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SMM_DATA_W-1:0] b_word;
   logic [SMM_DATA_W-1:0] prod_ff, prod_in;
   logic [SMM_DATA_W-1:0] acc_ff, acc_in;
   logic [SMM_DATA_W-1:0] drain_ff, drain_in;
   logic [SMM_DATA_W-1:0] acc_sum;
   logic                  col_hit;
   logic                  active;

   // B column store, one word per row k
   assign col_hit = ctrl.b_write && (ctrl.col == SMM_IDX_W'(INDEX));

   smm_ram #(
      .WIDTH (SMM_DATA_W),
      .DEPTH (DEPTH)
   ) u_b_col (
      .clock   (clock),
      .wr_en   (col_hit),
      .wr_addr (ctrl.row[AW-1:0]),
      .wr_data (ctrl.value),
      .rd_en   (ctrl.a_read),
      .rd_addr (ctrl.col[AW-1:0]),
      .rd_data (b_word)
   );

   // multiply stage, low word only
   always_comb begin
      prod_in = prod_ff;
      if (ctrl.prod_load) begin
         prod_in = SMM_DATA_W'(b_word * ctrl.a_value);
      end
   end

   // accumulate stage: only columns inside the side length take part
   assign active  = SMM_SIZE_W'(INDEX) < ctrl.n;
   assign acc_sum = active ? acc_ff + prod_ff : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_step) begin
         acc_in = ctrl.acc_close ? '0 : acc_sum;
      end
   end

   // load a closed row, else advance the chain towards the output
   always_comb begin
      drain_in = drain_ff;
      if (ctrl.acc_step && ctrl.acc_close) begin
         drain_in = acc_sum;
      end else if (ctrl.drain_shift) begin
         drain_in = chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      drain_ff <= drain_in;
   end

   assign chain_out = drain_ff;

endmodule

[test/tb_square_matrix_multiply.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_square_matrix_multiply
// Self-checking bench for the square matrix multiplier. Drives B writes and A
// rows through the request channel and keeps its own copy of the B store and
// the column accumulators. Every sum that leaves the response channel is
// compared with the oldest predicted C element. Phases cover several side
// lengths, idling on the request channel and stalling on the response channel.
// -----------------------------------------------------------------------------
module tb_square_matrix_multiply;
   import smm_pkg::*;

   localparam int SETTLE_CYCLES  = 8;     // pipeline depth plus margin
   localparam int HOLD_CYCLES    = 400;   // long response hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
   localparam int REPORT_LIMIT   = 10;

   // one predicted C element
   typedef struct packed {
      logic [SMM_IDX_W-1:0]  row;
      logic [SMM_IDX_W-1:0]  col;
      logic [SMM_DATA_W-1:0] sum;
      logic                  last;
   } row_sum_type;

   // tracks B, the accumulators and the C elements still to arrive
   class product_board;
      logic [SMM_SIZE_W-1:0] size_reg = SMM_SIZE_RESET;
      logic [SMM_DATA_W-1:0] b_store [SMM_MAX_SIZE*SMM_MAX_SIZE];
      bit                    b_written [SMM_MAX_SIZE*SMM_MAX_SIZE];
      logic [SMM_DATA_W-1:0] col_acc [SMM_FIELD_LIMIT] = '{default: '0};
      row_sum_type           pending_sums [$];
      int                    mismatches = 0;

      // saturate the side length to the range the block supports
      function int side();
         if (size_reg == 0) return 1;
         if (size_reg > SMM_FIELD_LIMIT) return SMM_FIELD_LIMIT;
         return int'(size_reg);
      endfunction

      // apply one accepted request; returns 0 when the block ignores it
      function bit note_request(smm_cmd_type cmd, logic [SMM_IDX_W-1:0] r,
                                logic [SMM_IDX_W-1:0] c, logic [SMM_DATA_W-1:0] v);
         int          n;
         row_sum_type res;
         n = side();
         if (r >= n || c >= n) return 1'b0;
         if (cmd == CMD_WRITE_B) begin
            b_store[r*SMM_MAX_SIZE + c]   = v;
            b_written[r*SMM_MAX_SIZE + c] = 1'b1;
            return 1'b1;
         end
         for (int j = 0; j < n; j++) begin
            col_acc[j] = col_acc[j] + v * b_store[c*SMM_MAX_SIZE + j];
         end
         // closing element: emit the row and clear every accumulator
         if (c == n - 1) begin
            for (int j = 0; j < n; j++) begin
               res.row  = r;
               res.col  = SMM_IDX_W'(j);
               res.sum  = col_acc[j];
               res.last = (j == n - 1);
               pending_sums.push_back(res);
            end
            foreach (col_acc[j]) col_acc[j] = '0;
         end
         return 1'b1;
      endfunction

      // compare one accepted sum with the oldest prediction
      function void check_sum(logic [SMM_IDX_W-1:0] r, logic [SMM_IDX_W-1:0] c,
                              logic [SMM_DATA_W-1:0] s, logic l);
         row_sum_type want;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected sum: row %0d col %0d sum %h last %b", r, c, s, l);
            return;
         end
         want = pending_sums.pop_front();
         if (want.row !== r || want.col !== c || want.sum !== s || want.last !== l) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"sum mismatch: expected row %0d col %0d sum %h last %b, ",
                         "got row %0d col %0d sum %h last %b"},
                        want.row, want.col, want.sum, want.last, r, c, s, l);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [SMM_SIZE_W-1:0] csr_wr_data;

   smm_req_if req_bus ();
   smm_rsp_if rsp_bus ();

   product_board board;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   bit           hold_request   = 1'b0;
   int           useful_items   = 0;
   int           idle_cycles    = 0;

   square_matrix_multiply dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // end the run when no handshake happens for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // accept sums, stall at random and hold off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_sum(rsp_bus.out_row, rsp_bus.out_col, rsp_bus.sum, rsp_bus.last);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   // random words, small values and often the extremes
   function automatic logic [SMM_DATA_W-1:0] pick_value();
      case ($urandom_range(7, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         4:       return SMM_DATA_W'($urandom_range(15, 0));
         default: return $urandom;
      endcase
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(input smm_cmd_type cmd, input logic [SMM_IDX_W-1:0] r,
                               input logic [SMM_IDX_W-1:0] c,
                               input logic [SMM_DATA_W-1:0] v);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.row     <= r;
      req_bus.col     <= c;
      req_bus.value   <= v;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (board.note_request(cmd, r, c, v)) useful_items++;
   endtask

   // stream one in-range A element, filling its B row first where needed
   task automatic stream_a(input logic [SMM_IDX_W-1:0] r, input logic [SMM_IDX_W-1:0] k);
      int n;
      n = board.side();
      for (int j = 0; j < n; j++) begin
         if (!board.b_written[k*SMM_MAX_SIZE + j])
            send_request(CMD_WRITE_B, k, SMM_IDX_W'(j), pick_value());
      end
      send_request(CMD_STREAM_A, r, k, pick_value());
   endtask

   // drop valid and wait until every predicted sum has arrived
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the side length once the block is idle
   task automatic write_size(input logic [SMM_SIZE_W-1:0] size_val);
      drain_requests();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size_val;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      board.size_reg = size_val;
   endtask

   // one phase of random traffic at a given side length and idling mix
   task automatic run_phase(input logic [SMM_SIZE_W-1:0] size_val, input int items,
                            input int idle_pct, input int stall_pct, input bit hold);
      int                   n;
      int                   target;
      int                   pick;
      logic [SMM_IDX_W-1:0] r;
      write_size(size_val);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (hold) hold_request = 1'b1;
      n      = board.side();
      target = useful_items + items;
      while (useful_items < target) begin
         pick = $urandom_range(99, 0);
         r    = SMM_IDX_W'($urandom_range(n - 1, 0));
         if (pick < 65) begin
            // whole row in order
            for (int k = 0; k < n; k++) stream_a(r, SMM_IDX_W'(k));
         end else if (pick < 80) begin
            // rewrite a B element
            send_request(CMD_WRITE_B, r, SMM_IDX_W'($urandom_range(n - 1, 0)), pick_value());
         end else if (pick < 90 || n == SMM_FIELD_LIMIT) begin
            // lone element, mixes rows or leaves a row open
            stream_a(r, SMM_IDX_W'($urandom_range(n - 1, 0)));
         end else if ($urandom_range(1, 0) == 1) begin
            // row out of range, ignored
            send_request(smm_cmd_type'($urandom_range(1, 0)),
                         SMM_IDX_W'($urandom_range(15, n)),
                         SMM_IDX_W'($urandom_range(15, 0)), pick_value());
         end else begin
            // column out of range, ignored
            send_request(smm_cmd_type'($urandom_range(1, 0)),
                         SMM_IDX_W'($urandom_range(15, 0)),
                         SMM_IDX_W'($urandom_range(15, n)), pick_value());
         end
      end
   endtask

   initial begin
      board = new;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= SMM_SIZE_RESET;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_WRITE_B;
      req_bus.row     <= '0;
      req_bus.col     <= '0;
      req_bus.value   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: 2 x 2 with extreme values
      write_size(5'd2);
      send_request(CMD_WRITE_B,  4'd0,  4'd0,  32'h7FFF_FFFF);
      send_request(CMD_WRITE_B,  4'd0,  4'd1,  32'h8000_0000);
      send_request(CMD_WRITE_B,  4'd1,  4'd0,  32'hFFFF_FFFF);
      send_request(CMD_WRITE_B,  4'd1,  4'd1,  32'h0000_0001);
      send_request(CMD_STREAM_A, 4'd0,  4'd0,  32'h8000_0000);
      send_request(CMD_STREAM_A, 4'd0,  4'd1,  32'h7FFF_FFFF);
      send_request(CMD_STREAM_A, 4'd1,  4'd0,  32'hFFFF_FFFF);
      send_request(CMD_STREAM_A, 4'd1,  4'd1,  32'h0000_0000);
      // indices beyond the side length are dropped
      send_request(CMD_WRITE_B,  4'd15, 4'd15, 32'h0000_0005);
      send_request(CMD_STREAM_A, 4'd0,  4'd15, 32'h0000_0007);
      send_request(CMD_STREAM_A, 4'd15, 4'd0,  32'h0000_0007);
      send_request(CMD_STREAM_A, 4'd15, 4'd15, 32'h0000_0007);
      // rows mixed before the close take the closing row
      send_request(CMD_STREAM_A, 4'd1,  4'd0,  32'h0000_0003);
      send_request(CMD_STREAM_A, 4'd0,  4'd1,  32'h0000_0005);
      // rewritten B applies to later elements
      send_request(CMD_WRITE_B,  4'd1,  4'd1,  32'h7FFF_FFFF);
      send_request(CMD_STREAM_A, 4'd1,  4'd0,  32'h0000_0002);
      send_request(CMD_STREAM_A, 4'd1,  4'd1,  32'h7FFF_FFFF);
      send_request(CMD_STREAM_A, 4'd0,  4'd0,  32'h0000_0000);
      send_request(CMD_STREAM_A, 4'd0,  4'd1,  32'h0000_0000);

      // random phases: size, items, sender idle, receiver stall, hold-off
      run_phase(5'd0,  30, 0,  0,  1'b0);
      run_phase(5'd4,  70, 72, 0,  1'b0);
      run_phase(5'd31, 20, 0,  72, 1'b0);
      run_phase(5'd7,  70, 19, 19, 1'b0);
      run_phase(5'd2,  60, 0,  0,  1'b1);
      run_phase(5'd16, 20, 0,  0,  1'b0);
      run_phase(5'd13, 60, 0,  72, 1'b0);
      run_phase(5'd1,  30, 72, 0,  1'b0);

      drain_requests();
      if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/smm_pkg.sv
hdl/smm_if.sv
hdl/smm_ram.sv
hdl/smm_cell.sv
hdl/square_matrix_multiply.sv
test/tb_square_matrix_multiply.sv
